// ===== src/adam_optimizer_update_macros.svh =====
// assertion macros of the adam update engine, used by adam_front
// no dependencies
`ifndef ADAM_OPTIMIZER_UPDATE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_MACROS_SVH

// condition must never hold outside reset
`define ADAM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define ADAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ADAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/adam_pkg.sv =====
// shared types and constants of the adam update engine
// no dependencies
`default_nettype none
package adam_pkg;
    localparam int SLOT_DEPTH  = 4096;
    localparam int SLOT_W      = $clog2(SLOT_DEPTH);
    localparam int IDX_W       = 12;
    localparam int GRAD_W      = 32;
    localparam int M_W         = 32;
    localparam int V_W         = 64;
    localparam int LR_W        = 25;
    localparam int BETA_W      = 24;
    localparam int EPS_W       = 16;
    localparam int POW_W       = 25;
    localparam int Q_FRAC      = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 25;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 90;
    localparam int DIV_NUM_W   = 88;
    localparam int DIV_DEN_W   = 33;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);
    localparam int SQ_IN_W     = 64;
    localparam int SQ_OUT_W    = 32;
    localparam int SQ_CNT_W    = $clog2(SQ_OUT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_LR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_B1   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B2   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS  = 2'd3;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_ITER   = 1'b1;

    localparam logic [POW_W-1:0] ONE_Q24 = POW_W'(1) << Q_FRAC;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (Q_FRAC - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (Q_FRAC - 1);

    typedef struct packed {
        logic                     op;
        logic [SLOT_W-1:0]        slot;
        logic signed [GRAD_W-1:0] gradient;
    } t_item;

    typedef struct packed {
        logic pop;
        logic busy;
    } t_back_stat;
endpackage
`default_nettype wire

// ===== src/adam_front.sv =====
// front end: takes update requests and queues them for the back end
// depends on adam_pkg and adam_optimizer_update_macros.svh
`default_nettype none
`include "adam_optimizer_update_macros.svh"
module adam_front (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_op,
    input  wire  [adam_pkg::IDX_W-1:0]            i_slot_index,
    input  wire  signed [adam_pkg::GRAD_W-1:0]    i_gradient,
    output adam_pkg::t_item                       o_head,
    output logic                                  o_head_valid,
    input  adam_pkg::t_back_stat                  i_back
);
    adam_pkg::t_item                  r_q [adam_pkg::QUEUE_DEPTH];
    logic [adam_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [adam_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [adam_pkg::QCNT_W-1:0]      r_count;
    logic                             push;
    logic                             pop;
    adam_pkg::t_item                  new_item;

    function automatic logic [adam_pkg::QPTR_W-1:0] ptr_inc(
        input logic [adam_pkg::QPTR_W-1:0] p);
        if (p == adam_pkg::QPTR_W'(adam_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + adam_pkg::QPTR_W'(1);
    endfunction

    assign o_in_stall   = (r_count == adam_pkg::QCNT_W'(adam_pkg::QUEUE_DEPTH)) || i_back.busy;
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_back.pop;
    assign o_head       = r_q[r_rd_ptr];
    assign o_head_valid = (r_count != '0);

    always_comb begin
        new_item.op       = i_op;
        new_item.slot     = i_slot_index[adam_pkg::SLOT_W-1:0];
        new_item.gradient = i_gradient;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= new_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + adam_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - adam_pkg::QCNT_W'(1);
            end
        end
    end

    `ADAM_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, pop, r_count != '0, "pop from empty queue")
    `ADAM_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > adam_pkg::QCNT_W'(adam_pkg::QUEUE_DEPTH), "queue overfilled")
    `ADAM_ASSERT_NEXT(a_count_grow, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + adam_pkg::QCNT_W'(1), "queue count lost a push")
endmodule
`default_nettype wire

// ===== src/adam_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on adam_pkg
`default_nettype none
module adam_div (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [adam_pkg::DIV_NUM_W-1:0]     i_num,
    input  wire  [adam_pkg::DIV_DEN_W-1:0]     i_den,
    output logic                               o_done,
    output logic [adam_pkg::DIV_NUM_W-1:0]     o_quo
);
    logic [adam_pkg::DIV_NUM_W-1:0]  r_quo;
    logic [adam_pkg::DIV_DEN_W-1:0]  r_rem;
    logic [adam_pkg::DIV_DEN_W-1:0]  r_den;
    logic [adam_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic [adam_pkg::DIV_DEN_W:0]    sh;
    logic [adam_pkg::DIV_DEN_W:0]    diff;
    logic                            take;

    assign sh     = {r_rem, r_quo[adam_pkg::DIV_NUM_W-1]};
    assign take   = (sh >= {1'b0, r_den});
    assign diff   = sh - {1'b0, r_den};
    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[adam_pkg::DIV_NUM_W-2:0], take};
            r_rem <= take ? diff[adam_pkg::DIV_DEN_W-1:0] : sh[adam_pkg::DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == adam_pkg::DIV_CNT_W'(adam_pkg::DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + adam_pkg::DIV_CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/adam_sqrt.sv =====
// digit-by-digit integer square root, one result bit per cycle
// depends on adam_pkg
`default_nettype none
module adam_sqrt (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [adam_pkg::SQ_IN_W-1:0]       i_rad,
    output logic                               o_done,
    output logic [adam_pkg::SQ_OUT_W-1:0]      o_root
);
    localparam int REM_W = adam_pkg::SQ_OUT_W + 2;

    logic [adam_pkg::SQ_IN_W-1:0]   r_rad;
    logic [REM_W-1:0]               r_rem;
    logic [adam_pkg::SQ_OUT_W-1:0]  r_root;
    logic [adam_pkg::SQ_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [REM_W+1:0]               rem_sh;
    logic [REM_W+1:0]               trial;
    logic [REM_W+1:0]               diff;
    logic                           take;

    assign rem_sh = {r_rem, r_rad[adam_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[adam_pkg::SQ_IN_W-3:0], 2'b00};
            r_rem  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            r_root <= {r_root[adam_pkg::SQ_OUT_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == adam_pkg::SQ_CNT_W'(adam_pkg::SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + adam_pkg::SQ_CNT_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/adam_back.sv =====
// back end: moment stores, shared multiplier, sequencer, divider and root units
// depends on adam_pkg, adam_div and adam_sqrt
`default_nettype none
module adam_back (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [adam_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [adam_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  adam_pkg::t_item                       i_head,
    input  wire                                   i_head_valid,
    output adam_pkg::t_back_stat                  o_stat,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic signed [adam_pkg::GRAD_W-1:0]    o_step
);
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_M0    = 5'd2;
    localparam logic [4:0] S_M1    = 5'd3;
    localparam logic [4:0] S_M2    = 5'd4;
    localparam logic [4:0] S_M3    = 5'd5;
    localparam logic [4:0] S_M4    = 5'd6;
    localparam logic [4:0] S_M5    = 5'd7;
    localparam logic [4:0] S_M6    = 5'd8;
    localparam logic [4:0] S_M7    = 5'd9;
    localparam logic [4:0] S_M8    = 5'd10;
    localparam logic [4:0] S_D1    = 5'd11;
    localparam logic [4:0] S_D2    = 5'd12;
    localparam logic [4:0] S_SQ    = 5'd13;
    localparam logic [4:0] S_L0    = 5'd14;
    localparam logic [4:0] S_L1    = 5'd15;
    localparam logic [4:0] S_L2    = 5'd16;
    localparam logic [4:0] S_D3    = 5'd17;
    localparam logic [4:0] S_P0    = 5'd18;
    localparam logic [4:0] S_P1    = 5'd19;
    localparam logic [4:0] S_P2    = 5'd20;
    localparam logic [4:0] S_DONE  = 5'd21;

    localparam int ACC_W = adam_pkg::ACC_W;
    localparam int MUL_W = adam_pkg::MUL_W;
    localparam int Q     = adam_pkg::Q_FRAC;
    localparam logic signed [ACC_W-1:0] M_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] M_MIN = ACC_W'(-64'sd2147483648);
    localparam logic [adam_pkg::M_W-1:0] LIM_POS = 32'h7fffffff;
    localparam logic [adam_pkg::M_W-1:0] LIM_NEG = 32'h80000000;

    logic [adam_pkg::M_W-1:0] m_mem [adam_pkg::SLOT_DEPTH];
    logic [adam_pkg::V_W-1:0] v_mem [adam_pkg::SLOT_DEPTH];

    logic [4:0]                          r_state;
    logic [adam_pkg::SLOT_W-1:0]         r_clr;
    logic [adam_pkg::LR_W-1:0]           r_lr;
    logic [adam_pkg::BETA_W-1:0]         r_b1;
    logic [adam_pkg::BETA_W-1:0]         r_b2;
    logic [adam_pkg::EPS_W-1:0]          r_eps;
    logic [adam_pkg::POW_W-1:0]          r_p1;
    logic [adam_pkg::POW_W-1:0]          r_p2;
    logic                                r_started;
    logic signed [adam_pkg::M_W-1:0]     r_m_rd;
    logic [adam_pkg::V_W-1:0]            r_v_rd;
    logic signed [adam_pkg::PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]             r_acc;
    logic signed [adam_pkg::M_W-1:0]     r_m;
    logic [62:0]                         r_g2;
    logic [adam_pkg::V_W-1:0]            r_vnew;
    logic [55:0]                         r_mag;
    logic [adam_pkg::DIV_DEN_W-1:0]      r_root;
    logic [adam_pkg::M_W-1:0]            r_res;
    logic                                r_out_valid;
    logic signed [adam_pkg::GRAD_W-1:0]  r_step;

    logic signed [MUL_W-1:0]             mul_a;
    logic signed [MUL_W-1:0]             mul_b;
    logic [adam_pkg::POW_W-1:0]          c1;
    logic [adam_pkg::POW_W-1:0]          c2;
    logic [adam_pkg::POW_W-1:0]          d1;
    logic [adam_pkg::POW_W-1:0]          d2;
    logic [adam_pkg::M_W-1:0]            ag;
    logic [adam_pkg::M_W-1:0]            m_abs;
    logic [adam_pkg::M_W-1:0]            limit;
    logic signed [ACC_W-1:0]             t_m;
    logic signed [ACC_W-1:0]             s_m;
    logic signed [adam_pkg::M_W-1:0]     m_new;
    logic signed [ACC_W-1:0]             t_v;
    logic [ACC_W-Q-1:0]                  u_v;
    logic [adam_pkg::V_W-1:0]            v_new;
    logic signed [adam_pkg::PROD_W-1:0]  t_p;
    logic                                out_free;
    logic                                m_we;
    logic                                v_we;
    logic [adam_pkg::SLOT_W-1:0]         mem_addr;

    logic                                div_start;
    logic [adam_pkg::DIV_NUM_W-1:0]      div_num;
    logic [adam_pkg::DIV_DEN_W-1:0]      div_den;
    logic                                div_done;
    logic [adam_pkg::DIV_NUM_W-1:0]      div_quo;
    logic                                sq_start;
    logic [adam_pkg::SQ_IN_W-1:0]        sq_rad;
    logic                                sq_done;
    logic [adam_pkg::SQ_OUT_W-1:0]       sq_root;

    adam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    adam_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_step      = r_step;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign c1 = adam_pkg::ONE_Q24 - {1'b0, r_b1};
    assign c2 = adam_pkg::ONE_Q24 - {1'b0, r_b2};
    assign d1 = (r_started && (r_p1 < adam_pkg::ONE_Q24)) ? adam_pkg::ONE_Q24 - r_p1
                                                          : adam_pkg::ONE_Q24;
    assign d2 = (r_started && (r_p2 < adam_pkg::ONE_Q24)) ? adam_pkg::ONE_Q24 - r_p2
                                                          : adam_pkg::ONE_Q24;
    assign ag    = i_head.gradient[adam_pkg::GRAD_W-1] ? adam_pkg::M_W'(-i_head.gradient)
                                                       : adam_pkg::M_W'(i_head.gradient);
    assign m_abs = r_m[adam_pkg::M_W-1] ? adam_pkg::M_W'(-r_m) : adam_pkg::M_W'(r_m);
    assign limit = r_m[adam_pkg::M_W-1] ? LIM_NEG : LIM_POS;

    // first moment round and clamp
    assign t_m   = r_acc + adam_pkg::ACC_HALF;
    assign s_m   = t_m >>> Q;
    assign m_new = (s_m > M_MAX) ? adam_pkg::M_W'(M_MAX)
                 : (s_m < M_MIN) ? adam_pkg::M_W'(M_MIN) : s_m[adam_pkg::M_W-1:0];

    // second moment round and saturate
    assign t_v   = r_acc + adam_pkg::ACC_HALF;
    assign u_v   = t_v[ACC_W-1:Q];
    assign v_new = (|u_v[ACC_W-Q-1:adam_pkg::V_W]) ? '1 : u_v[adam_pkg::V_W-1:0];

    assign t_p = r_prod + adam_pkg::PROD_HALF;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_M0: begin
                mul_a = MUL_W'({1'b0, r_b1});
                mul_b = MUL_W'(r_m_rd);
            end
            S_M1: begin
                mul_a = MUL_W'({1'b0, c1});
                mul_b = MUL_W'(i_head.gradient);
            end
            S_M2: begin
                mul_a = {1'b0, ag};
                mul_b = {1'b0, ag};
            end
            S_M3: begin
                mul_a = MUL_W'({1'b0, r_b2});
                mul_b = {1'b0, r_v_rd[31:0]};
            end
            S_M4: begin
                mul_a = MUL_W'({1'b0, r_b2});
                mul_b = {1'b0, r_v_rd[63:32]};
            end
            S_M5: begin
                mul_a = MUL_W'({1'b0, c2});
                mul_b = {1'b0, r_g2[31:0]};
            end
            S_M6: begin
                mul_a = MUL_W'({1'b0, c2});
                mul_b = MUL_W'({1'b0, r_g2[62:32]});
            end
            S_SQ: begin
                mul_a = MUL_W'({1'b0, r_lr});
                mul_b = {1'b0, r_mag[31:0]};
            end
            S_L0: begin
                mul_a = MUL_W'({1'b0, r_lr});
                mul_b = MUL_W'({1'b0, r_mag[55:32]});
            end
            S_P0: begin
                mul_a = MUL_W'({1'b0, r_p1});
                mul_b = MUL_W'({1'b0, r_b1});
            end
            S_P1: begin
                mul_a = MUL_W'({1'b0, r_p2});
                mul_b = MUL_W'({1'b0, r_b2});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        sq_rad    = '0;
        if (r_state == S_M8) begin
            div_start = 1'b1;
            div_num   = adam_pkg::DIV_NUM_W'({m_abs, 24'b0});
            div_den   = adam_pkg::DIV_DEN_W'(d1);
        end else if (r_state == S_D1 && div_done) begin
            div_start = 1'b1;
            div_num   = {r_vnew, 24'b0};
            div_den   = adam_pkg::DIV_DEN_W'(d2);
        end else if (r_state == S_L2 && r_root != '0) begin
            div_start = 1'b1;
            div_num   = r_acc[adam_pkg::DIV_NUM_W-1:0];
            div_den   = r_root;
        end
        if (r_state == S_D2 && div_done) begin
            sq_start = 1'b1;
            sq_rad   = (|div_quo[adam_pkg::DIV_NUM_W-1:adam_pkg::V_W]) ? '1
                                                                     : div_quo[adam_pkg::V_W-1:0];
        end
    end

    assign m_we     = (r_state == S_CLEAR) || (r_state == S_M3);
    assign v_we     = (r_state == S_CLEAR) || (r_state == S_M8);
    assign mem_addr = (r_state == S_CLEAR) ? r_clr : i_head.slot;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            m_mem[mem_addr] <= (r_state == S_CLEAR) ? '0 : m_new;
        end
        if (v_we) begin
            v_mem[mem_addr] <= (r_state == S_CLEAR) ? '0 : v_new;
        end
        if (r_state == S_IDLE) begin
            r_m_rd <= m_mem[i_head.slot];
            r_v_rd <= v_mem[i_head.slot];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_M1: r_acc <= ACC_W'(r_prod);
            S_M2: r_acc <= r_acc + ACC_W'(r_prod);
            S_M3: begin
                r_m  <= m_new;
                r_g2 <= r_prod[62:0];
            end
            S_M4: r_acc <= ACC_W'(r_prod);
            S_M5: r_acc <= r_acc + (ACC_W'(r_prod) <<< 32);
            S_M6: r_acc <= r_acc + ACC_W'(r_prod);
            S_M7: r_acc <= r_acc + (ACC_W'(r_prod) <<< 32);
            S_M8: r_vnew <= v_new;
            S_D1: begin
                if (div_done) begin
                    r_mag <= div_quo[55:0];
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    r_root <= adam_pkg::DIV_DEN_W'(sq_root) + adam_pkg::DIV_DEN_W'(r_eps);
                end
            end
            S_L0: r_acc <= ACC_W'(r_prod);
            S_L1: r_acc <= r_acc + (ACC_W'(r_prod) <<< 32);
            S_L2: begin
                if (r_root == '0) begin
                    r_res <= (r_mag == '0) ? '0 : limit;
                end
            end
            S_D3: begin
                if (div_done) begin
                    r_res <= (div_quo > adam_pkg::DIV_NUM_W'(limit)) ? limit
                                                                      : div_quo[31:0];
                end
            end
            S_P2: r_res <= '0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_lr        <= 25'd16777;
            r_b1        <= 24'd15099494;
            r_b2        <= 24'd16760438;
            r_eps       <= 16'd1;
            r_p1        <= adam_pkg::ONE_Q24;
            r_p2        <= adam_pkg::ONE_Q24;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    adam_pkg::CFG_LR:  r_lr  <= i_cfg_data;
                    adam_pkg::CFG_B1:  r_b1  <= i_cfg_data[adam_pkg::BETA_W-1:0];
                    adam_pkg::CFG_B2:  r_b2  <= i_cfg_data[adam_pkg::BETA_W-1:0];
                    adam_pkg::CFG_EPS: r_eps <= i_cfg_data[adam_pkg::EPS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && !i_out_stall && !((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + adam_pkg::SLOT_W'(1);
                    if (r_clr == adam_pkg::SLOT_W'(adam_pkg::SLOT_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_state <= (i_head.op == adam_pkg::OP_ITER) ? S_P0 : S_M0;
                    end
                end
                S_M0: r_state <= S_M1;
                S_M1: r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_M4;
                S_M4: r_state <= S_M5;
                S_M5: r_state <= S_M6;
                S_M6: r_state <= S_M7;
                S_M7: r_state <= S_M8;
                S_M8: r_state <= S_D1;
                S_D1: begin
                    if (div_done) begin
                        r_state <= S_D2;
                    end
                end
                S_D2: begin
                    if (div_done) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (sq_done) begin
                        r_state <= S_L0;
                    end
                end
                S_L0: r_state <= S_L1;
                S_L1: r_state <= S_L2;
                S_L2: r_state <= (r_root == '0) ? S_DONE : S_D3;
                S_D3: begin
                    if (div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_p1    <= t_p[Q+adam_pkg::POW_W-1:Q];
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_p2      <= t_p[Q+adam_pkg::POW_W-1:Q];
                    r_started <= 1'b1;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_step      <= (i_head.op == adam_pkg::OP_UPDATE && r_m[adam_pkg::M_W-1])
                                       ? -$signed(r_res) : $signed(r_res);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state == S_CLEAR);
    assign o_stat.pop  = (r_state == S_DONE) && out_free;
endmodule
`default_nettype wire

// ===== src/adam_optimizer_update.sv =====
// update request: three divisions on the shared divider (two when the root is zero), one root, multiply steps
// begin-iteration request: states P0, P1, P2; one request in flight, one more waits in the queue
// updates do not overlap: the next starts only once the last is done, on the shared restoring divider
// after reset all 4096 slots of the moment stores are swept to zero with input stalled
// configuration writes are taken in every cycle, during the sweep too
// top level of the adam update engine, depends on adam_pkg, adam_front and adam_back
`default_nettype none
module adam_optimizer_update (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire                                   i_op,
    input  wire  [adam_pkg::IDX_W-1:0]            i_slot_index,
    input  wire  signed [adam_pkg::GRAD_W-1:0]    i_gradient,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output logic signed [adam_pkg::GRAD_W-1:0]    o_step,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [adam_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [adam_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    adam_pkg::t_item       head;
    logic                  head_valid;
    adam_pkg::t_back_stat  back_stat;

    adam_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_slot_index (i_slot_index),
        .i_gradient   (i_gradient),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_back       (back_stat)
    );

    adam_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_stat       (back_stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_step       (o_step)
    );
endmodule
`default_nettype wire

// ===== verif/adam_update_checker.sv =====
// request/result checker for the adam update engine: predicts each step and compares
// depends on adam_pkg; instantiated beside the engine by tb_top
`default_nettype none
module adam_update_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    input  wire                                i_in_stall,
    input  wire                                i_op,
    input  wire  [adam_pkg::IDX_W-1:0]         i_slot_index,
    input  wire  signed [adam_pkg::GRAD_W-1:0] i_gradient,
    input  wire                                i_out_valid,
    input  wire                                i_out_stall,
    input  wire  signed [adam_pkg::GRAD_W-1:0] i_step,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire  [adam_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [adam_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_errors,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import adam_pkg::*;

    localparam longint unsigned ONE  = 64'd16777216;
    localparam longint unsigned HALF = 64'd8388608;
    localparam longint unsigned LOW  = 64'd16777215;
    localparam longint unsigned SAT  = 64'hFFFF_FFFF_FFFF_FFFF;

    int              moment_one [SLOT_DEPTH];
    longint unsigned moment_two [SLOT_DEPTH];
    longint unsigned power_one, power_two;
    bit              started;
    longint unsigned lr, b1, b2, eps;
    logic signed [GRAD_W-1:0] step_queue[$];

    function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s < a) ? SAT : s;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned divisor(longint unsigned p);
        if (!started || p >= ONE || ONE - p == 0) return ONE;
        return ONE - p;
    endfunction

    function automatic logic [GRAD_W-1:0] predict_step(logic op, logic [IDX_W-1:0] idx,
                                                      logic signed [GRAD_W-1:0] grad);
        longint g, m, sum;
        longint unsigned ag, g2, c2, v, low_part, d1, d2, mag, q, rem, vhat, root;
        longint unsigned limit, res, q1, r1;
        int slot;
        bit neg;
        if (op == OP_ITER) begin
            power_one = (power_one * b1 + HALF) >> 24;
            power_two = (power_two * b2 + HALF) >> 24;
            started = 1;
            return '0;
        end
        slot = int'(idx) % SLOT_DEPTH;
        g = longint'(grad);
        sum = longint'(b1) * longint'(moment_one[slot]) + longint'(ONE - b1) * g;
        m = (sum + longint'(HALF)) >>> 24;
        if (m > 64'sd2147483647) m = 64'sd2147483647;
        if (m < -64'sd2147483648) m = -64'sd2147483648;
        moment_one[slot] = int'(m);

        ag = (g < 0) ? longint'(-g) : longint'(g);
        g2 = ag * ag;
        c2 = ONE - b2;
        v = moment_two[slot];
        low_part = (b2 * (v & LOW) + c2 * (g2 & LOW) + HALF) >> 24;
        v = sat_sum(sat_sum(b2 * (v >> 24), c2 * (g2 >> 24)), low_part);
        moment_two[slot] = v;

        d1 = divisor(power_one);
        d2 = divisor(power_two);
        neg = m < 0;
        mag = ((neg ? longint'(-m) : longint'(m)) << 24) / d1;
        q = v / d2;
        rem = v % d2;
        if (q >= (64'd1 << 40)) vhat = SAT;
        else vhat = sat_sum(q << 24, (rem << 24) / d2);
        root = int_sqrt(vhat) + eps;

        limit = neg ? 64'd2147483648 : 64'd2147483647;
        if (root == 0) begin
            res = (mag == 0) ? 0 : limit;
        end else begin
            q1 = mag / root;
            r1 = mag % root;
            if (lr != 0 && q1 > limit / lr) res = limit;
            else res = q1 * lr + (r1 * lr) / root;
            if (res > limit) res = limit;
        end
        if (neg) res = 64'd0 - res;
        return res[GRAD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (moment_one[k]) begin
                moment_one[k] = 0;
                moment_two[k] = 0;
            end
            power_one = ONE;
            power_two = ONE;
            started = 0;
            lr = 16777;
            b1 = 15099494;
            b2 = 16760438;
            eps = 1;
            step_queue.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LR:  lr  = i_cfg_data;
                    CFG_B1:  b1  = i_cfg_data[BETA_W-1:0];
                    CFG_B2:  b2  = i_cfg_data[BETA_W-1:0];
                    CFG_EPS: eps = i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (step_queue.size() == 0) begin
                    $error("step %0d arrived with no request outstanding", i_step);
                    o_errors <= o_errors + 1;
                end else begin
                    if (i_step !== step_queue[0]) begin
                        $error("step: expected %0d, actual %0d", step_queue[0], i_step);
                        o_errors <= o_errors + 1;
                    end
                    void'(step_queue.pop_front());
                end
            end
            if (i_in_valid && !i_in_stall)
                step_queue.push_back(predict_step(i_op, i_slot_index, i_gradient));
        end
        o_pending <= step_queue.size();
    end
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// stimulus and verdict for the adam update engine
// depends on adam_pkg, adam_optimizer_update and adam_update_checker
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import adam_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic i_op = 0;
    logic [IDX_W-1:0] i_slot_index = '0;
    logic signed [GRAD_W-1:0] i_gradient = '0;
    logic i_out_stall = 0;
    logic i_cfg_valid = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    wire  o_in_stall, o_out_valid, o_cfg_ready;
    wire  signed [GRAD_W-1:0] o_step;
    int   errors, pending;
    int   cycles = 0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   burst_left = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    adam_optimizer_update DUT (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_op, .i_slot_index, .i_gradient,
        .o_out_valid, .i_out_stall, .o_step, .i_cfg_valid, .o_cfg_ready, .i_cfg_index,
        .i_cfg_data
    );

    adam_update_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_op, .i_slot_index,
        .i_gradient, .i_out_valid(o_out_valid), .i_out_stall, .i_step(o_step),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** adam_optimizer_update: FAILED **");
            $finish;
        end
    end

    // receiver stall: long hold-off on request, else a rotating pattern of four stall modes
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1;
            hold_left <= hold_left - 1;
        end else if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= 1500;
            i_out_stall <= 1;
        end else begin
            case ((cycles / 64) % 4)
                0: i_out_stall <= 0;
                1: i_out_stall <= ($urandom_range(0, 1) == 1);
                2: i_out_stall <= ($urandom_range(0, 9) < 8);
                default: i_out_stall <= ((cycles % 5) < 2);
            endcase
        end
    end

    task automatic write_regs(logic [CFG_DATA_W-1:0] lr, logic [BETA_W-1:0] b1,
                              logic [BETA_W-1:0] b2, logic [EPS_W-1:0] eps);
        logic [CFG_DATA_W-1:0] vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        vals = '{lr, CFG_DATA_W'(b1), CFG_DATA_W'(b2), CFG_DATA_W'(eps)};
        idx = '{CFG_LR, CFG_B1, CFG_B2, CFG_EPS};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 0;
    endtask

    task automatic wait_drained();
        i_in_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic signed [GRAD_W-1:0] g);
        i_in_valid <= 1;
        i_op <= op;
        i_slot_index <= idx;
        i_gradient <= g;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_random(int count, bit small_grads);
        logic op;
        logic [IDX_W-1:0] idx;
        logic signed [GRAD_W-1:0] g;
        int gap;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 99) < 8) ? OP_ITER : OP_UPDATE;
            idx = ($urandom_range(0, 9) < 7) ? IDX_W'($urandom_range(0, 15)) : IDX_W'($urandom);
            case ($urandom_range(0, small_grads ? 1 : 3))
                0: g = $signed(GRAD_W'($urandom_range(0, 2))) - 1;
                1: g = $signed(GRAD_W'($urandom_range(0, 2097152))) - 1048576;
                default: g = $urandom;
            endcase
            send_request(op, idx, g);
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 20);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                if (gap != 0) begin
                    i_in_valid <= 0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        write_regs(25'd16777, 24'd15099494, 24'd16760438, 16'd1);
        send_request(OP_UPDATE, 12'd0, 32'sh7FFF_FFFF);
        send_request(OP_UPDATE, 12'd4095, -32'sh8000_0000);
        send_request(OP_UPDATE, 12'd1, 32'sd0);
        send_request(OP_UPDATE, 12'd2, 32'sd1);
        send_request(OP_UPDATE, 12'd2, -32'sd1);
        send_request(OP_ITER, 12'd4095, 32'sh7FFF_FFFF);
        send_request(OP_UPDATE, 12'd0, -32'sh8000_0000);
        send_request(OP_ITER, 12'd0, 32'sd0);
        send_request(OP_UPDATE, 12'd4095, 32'sh0100_0000);
        send_random(100, 0);
        // fill the engine while results are held back
        hold_asks <= hold_asks + 1;
        send_random(12, 0);
        send_random(100, 0);
        wait_drained();
        send_random(180, 0);
        wait_drained();

        // zero root: eps 0 with empty second moment
        write_regs(25'd16777216, 24'd0, 24'd16777215, 16'd0);
        send_request(OP_UPDATE, 12'd3000, 32'sd1);
        send_request(OP_UPDATE, 12'd3001, -32'sd1);
        send_request(OP_UPDATE, 12'd3002, 32'sd0);
        send_request(OP_UPDATE, 12'd3003, 32'sh7FFF_FFFF);
        send_random(150, 1);
        wait_drained();

        write_regs(25'd0, 24'd16777215, 24'd0, 16'd65535);
        send_request(OP_UPDATE, 12'd5, -32'sh8000_0000);
        send_request(OP_ITER, 12'd5, 32'sd0);
        send_random(150, 0);
        wait_drained();

        write_regs(CFG_DATA_W'($urandom_range(0, 16777216)), BETA_W'($urandom),
                   BETA_W'($urandom), EPS_W'($urandom));
        send_random(400, 0);
        wait_drained();

        write_regs(25'd16777, 24'd15099494, 24'd16760438, 16'd1);
        send_random(340, 0);
        wait_drained();

        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("** adam_optimizer_update: PASSED **");
        else
            $display("** adam_optimizer_update: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
